### rtl/keypad_code_entry_buffer_defines.svh
// ----------------------------------------------------------------------------
// Keypad code entry buffer: assertion macros
// Shared concurrent assertion macros; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_ENTRY_BUFFER_DEFINES_SVH
`define KEYPAD_CODE_ENTRY_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KCB_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("kcb assertion failed");

// next-cycle implication
`define KCB_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("kcb assertion failed");

`else

`define KCB_ASSERT_IMP(lbl, clk, rst, pre, post)
`define KCB_ASSERT_NXT(lbl, clk, rst, pre, post)

`endif

`endif

### rtl/kcb_pkg.sv
// ----------------------------------------------------------------------------
// kcb_pkg
// Types, codes and the key map shared by the keypad code entry buffer.
// ----------------------------------------------------------------------------
package kcb_pkg;

   localparam int ENTRY_DEPTH_DEF = 16;

   localparam logic [15:0] TIMEOUT_RESET = 16'd30000;
   localparam logic [16:0] IDLE_MAX      = 17'h1FFFF;

   localparam logic [7:0] ASCII_ZERO = 8'd48;
   localparam logic [7:0] CHAR_POUND = 8'h23;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;

   localparam logic [3:0] SYM_STAR  = 4'd10;
   localparam logic [3:0] SYM_POUND = 4'd11;

   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // response status codes
   localparam logic [1:0] ST_IGNORED  = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_EDIT     = 2'd2;
   localparam logic [1:0] ST_CHAR     = 2'd3;

   typedef struct packed {
      logic       kind;
      logic [7:0] scan_code;
      logic       alarm_busy;
      logic       voice_busy;
   } kcb_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] entry_char;
      logic [4:0] fill_level;
      logic       last;
   } kcb_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic take_item;
      logic emit_step;
   } kcb_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
      logic completes;
      logic emit_final;
   } kcb_stat_type;

   // scan code (0..16) to symbol: digits, star or pound
   function automatic logic [3:0] key_sym(input logic [4:0] code);
      logic [3:0] sym;
      case (code)
         5'd1:    sym = 4'd1;
         5'd2:    sym = 4'd2;
         5'd3:    sym = 4'd3;
         5'd4:    sym = 4'd4;
         5'd5:    sym = 4'd5;
         5'd6:    sym = 4'd6;
         5'd7:    sym = 4'd9;
         5'd8:    sym = 4'd8;
         5'd9:    sym = SYM_STAR;
         5'd11:   sym = SYM_POUND;
         5'd16:   sym = 4'd7;
         default: sym = 4'd0;
      endcase
      return sym;
   endfunction

endpackage

### rtl/kcb_ctrl.sv
// ----------------------------------------------------------------------------
// kcb_ctrl
// Sequencer: takes transactions while idle, then walks a completed entry out.
// ----------------------------------------------------------------------------
`include "keypad_code_entry_buffer_defines.svh"

module kcb_ctrl
   import kcb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  kcb_stat_type status,
   output kcb_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOAD,   // lets the read port see the final write
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready     = (state_ff == S_IDLE) && status.out_free;
   assign cmd.take_item = req_valid && req_ready;
   assign cmd.emit_step = (state_ff == S_EMIT) && status.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.take_item && status.completes) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (cmd.emit_step && status.emit_final) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `KCB_ASSERT_NXT(a_complete_to_load, clock, reset, cmd.take_item && status.completes, state_ff == S_LOAD)
   `KCB_ASSERT_NXT(a_load_to_emit, clock, reset, state_ff == S_LOAD, state_ff == S_EMIT)
   `KCB_ASSERT_NXT(a_final_to_idle, clock, reset, cmd.emit_step && status.emit_final, state_ff == S_IDLE)

endmodule

### rtl/kcb_datapath.sv
// ----------------------------------------------------------------------------
// kcb_datapath
// Key decode, entry store, idle timer, fill count and response register.
// ----------------------------------------------------------------------------
`include "keypad_code_entry_buffer_defines.svh"

module kcb_datapath
   import kcb_pkg::*;
#(
   parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   input  kcb_req_type  req_data,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output kcb_rsp_type  rsp_data,
   input  kcb_cmd_type  cmd,
   output kcb_stat_type status
);

   localparam int AW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
   localparam int FW = $clog2(ENTRY_DEPTH + 1);

   logic [15:0]   timeout_ff;
   logic [16:0]   idle_ff,  idle_in;
   logic [FW-1:0] fill_ff,  fill_in;
   logic [AW-1:0] emit_idx_ff, emit_idx_in;
   logic [AW-1:0] emit_end_ff;
   logic [7:0]    entry_store_ff [ENTRY_DEPTH];
   logic [7:0]    rd_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   kcb_rsp_type   rsp_data_ff,  rsp_data_in;

   logic          code_bad, key_ok, stale, full;
   logic          is_star, is_pound;
   logic          do_delete, do_append, do_complete;
   logic          key_take, tick_take, load_key, mem_we;
   logic [3:0]    sym;
   logic [FW-1:0] fill_eff;
   logic [FW+4:0] fill_wide;
   logic [7:0]    wr_char;
   logic          out_free;

   // ---- key decode ----
   assign code_bad = (|req_data.scan_code[7:5])
                   | (req_data.scan_code[4] & (|req_data.scan_code[3:0]));
   assign key_ok   = !code_bad && !req_data.alarm_busy && !req_data.voice_busy;
   assign sym      = key_sym(req_data.scan_code[4:0]);
   assign is_star  = (sym == SYM_STAR);
   assign is_pound = (sym == SYM_POUND);

   // stale partial entry is dropped before the key is applied
   assign stale    = (fill_ff != '0) && (idle_ff > {1'b0, timeout_ff});
   assign fill_eff = stale ? '0 : fill_ff;
   assign full     = (fill_eff >= FW'(ENTRY_DEPTH));

   assign do_delete   = key_ok && !full && is_star && (fill_eff != '0);
   assign do_append   = key_ok && !full && !is_star && !is_pound;
   assign do_complete = key_ok && !full && (is_pound || (is_star && (fill_eff == '0)));

   assign key_take  = cmd.take_item && (req_data.kind == KIND_KEY);
   assign tick_take = cmd.take_item && (req_data.kind == KIND_TICK);
   assign load_key  = key_take && !do_complete;
   assign mem_we    = key_take && (do_append || do_complete);

   assign wr_char = do_append ? (ASCII_ZERO + {4'b0000, sym})
                              : (is_pound ? CHAR_POUND : CHAR_STAR);

   // ---- next state ----
   always_comb begin
      fill_in = fill_ff;
      idle_in = idle_ff;
      if (tick_take && (idle_ff != IDLE_MAX)) begin
         idle_in = idle_ff + 17'd1;
      end
      if (key_take && key_ok) begin
         idle_in = '0;
         if (do_delete) begin
            fill_in = fill_eff - FW'(1);
         end else if (do_append) begin
            fill_in = fill_eff + FW'(1);
         end else begin
            fill_in = '0;   // overflow or completion
         end
      end
   end

   assign status.emit_final = (emit_idx_ff == emit_end_ff);

   always_comb begin
      emit_idx_in = emit_idx_ff;
      if (key_take && do_complete) begin
         emit_idx_in = '0;
      end else if (cmd.emit_step && !status.emit_final) begin
         emit_idx_in = emit_idx_ff + AW'(1);
      end
   end

   // ---- response register ----
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fill_wide = {5'b00000, fill_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (load_key) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.status     = !key_ok ? ST_IGNORED : (full ? ST_OVERFLOW : ST_EDIT);
         rsp_data_in.entry_char = 8'd0;
         rsp_data_in.fill_level = fill_wide[4:0];
         rsp_data_in.last       = 1'b1;
      end else if (cmd.emit_step) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.status     = ST_CHAR;
         rsp_data_in.entry_char = rd_data_ff;
         rsp_data_in.fill_level = 5'd0;
         rsp_data_in.last       = status.emit_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         idle_ff      <= '0;
         fill_ff      <= '0;
         emit_idx_ff  <= '0;
         emit_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         idle_ff      <= idle_in;
         fill_ff      <= fill_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (key_take && do_complete) begin
            emit_end_ff <= fill_eff[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // entry store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_store_ff[fill_eff[AW-1:0]] <= wr_char;
      end
      rd_data_ff <= entry_store_ff[emit_idx_in];
   end

   assign status.out_free  = out_free;
   assign status.completes = (req_data.kind == KIND_KEY) && do_complete;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

   `KCB_ASSERT_IMP(a_fill_range, clock, reset, 1'b1, fill_ff <= FW'(ENTRY_DEPTH))
   `KCB_ASSERT_IMP(a_no_overwrite, clock, reset, load_key || cmd.emit_step, out_free)
   `KCB_ASSERT_NXT(a_emit_char, clock, reset, cmd.emit_step, rsp_valid_ff && (rsp_data_ff.status == ST_CHAR))
   `KCB_ASSERT_IMP(a_emit_range, clock, reset, 1'b1, emit_idx_ff <= emit_end_ff)

endmodule

### rtl/keypad_code_entry_buffer.sv
// ----------------------------------------------------------------------------
// keypad_code_entry_buffer
// Collects keypad scan codes into a code entry and plays completed entries out.
// ----------------------------------------------------------------------------
// Each req transaction is either a key press or a one millisecond tick. A tick
// only advances the saturating idle timer and produces no response. A key
// produces exactly one response (ignored, overflow cleared or edit accepted),
// except pound, or star on an empty buffer, which completes the entry: the
// buffer then plays out one response per stored character with last set on
// the final one, and is cleared. Ticks and non-completing keys are taken
// whenever the block is idle and the response register is free, so a new
// transaction can be accepted in the same cycle that the previous response is
// taken. A completing key is accepted, then a load state lets the entry
// store's read port see the final write, then play-out gives one character
// per cycle while rsp is not stalled, paced by the single registered read
// port. No req transaction is taken during play-out.
// The idle timeout register is written through csr_wr_en / csr_wr_data and
// must only be written while the block is idle. There is no clearing pass
// after reset; entry store words are always written before they are read.
// ----------------------------------------------------------------------------
module keypad_code_entry_buffer
   import kcb_pkg::*;
#(
   parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF   // characters per entry, 2..31 (fill_level is 5 bits)
) (
   input  logic        clock,
   input  logic        reset,

   // idle timeout, milliseconds
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,

   // key / tick transactions
   input  logic        req_valid,
   output logic        req_ready,
   input  kcb_req_type req_data,

   // response transactions
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output kcb_rsp_type rsp_data
);

   kcb_cmd_type  cmd;
   kcb_stat_type status;

   // sequencer: idle / load / play-out
   kcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // decode, store, timers and response register
   kcb_datapath #(
      .ENTRY_DEPTH (ENTRY_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
